FILE: sv/assert_macros.svh
// Assertion macros for the RTL files; only the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and off during rst.
`define ASC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and off during rst.
`define ASC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/asc_pkg.sv
// Types and constants of the adaptive substep controller.
package asc_pkg;

  localparam int TICK_BITS  = 16;
  localparam int COUNT_BITS = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [TICK_BITS-1:0]  TICKS_RESET = TICK_BITS'(128);
  localparam logic [TICK_BITS-1:0]  SPS_RESET   = TICK_BITS'(1);
  localparam logic [COUNT_BITS-1:0] TOTAL_RESET = COUNT_BITS'(11);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TICKS_PER_STEP   = 2'd0,
    CFG_STEPS_PER_SAMPLE = 2'd1,
    CFG_TOTAL_STEPS      = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_ACCEPT       = 3'd0,
    ST_ACCEPT_RETRY = 3'd1,
    ST_ABORT        = 3'd2,
    ST_HALVE        = 3'd3,
    ST_MIN_RETRY    = 3'd4,
    ST_FROZEN       = 3'd5
  } status_t;

  typedef struct packed {
    logic [TICK_BITS-1:0]  ticks_per_step;
    logic [TICK_BITS-1:0]  steps_per_sample;
    logic [COUNT_BITS-1:0] total_steps;
  } cfg_t;

  typedef struct packed {
    logic [TICK_BITS-1:0]  offset_in_step;
    logic [TICK_BITS-1:0]  substep_size;
    logic [TICK_BITS-1:0]  last_tried_size;
    logic [COUNT_BITS-1:0] steps_completed;
    logic [TICK_BITS-1:0]  steps_in_sample;
    logic [COUNT_BITS-1:0] samples_completed;
    logic                  retry_mark;
    logic                  frozen_mark;
  } state_t;

  typedef struct packed {
    logic success;
    logic abort_request;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [TICK_BITS-1:0]  attempt_offset;
    logic [TICK_BITS-1:0]  attempt_size;
    logic [TICK_BITS-1:0]  next_offset;
    logic [TICK_BITS-1:0]  next_size;
    logic [COUNT_BITS-1:0] full_steps_done;
    logic [COUNT_BITS-1:0] sample_number;
    logic                  at_sample_start;
    logic                  at_sample_end;
    logic                  run_done;
  } out_item_t;

  function automatic logic [TICK_BITS-1:0] eff_ticks(input logic [TICK_BITS-1:0] t);
    return (t == '0) ? TICK_BITS'(1) : t;
  endfunction

endpackage

FILE: sv/adaptive_substep_controller.sv
// Top level of the adaptive substep controller.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_item   (success, abort_request)
//   out     | output    | out_valid / out_ready| out_item  (status, offsets, sizes, counters)
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A transaction passes through the input register, then through the step logic into the result
// register. One transaction per cycle is sustained while the output is not stalled; the step
// logic between the two registers is combinational.
// Reset is synchronous on rst; it loads the register defaults and clears all control state.
// A stalled output holds its result and the input register keeps one transaction waiting.
// Configuration writes are always taken.
module adaptive_substep_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  asc_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output asc_pkg::out_item_t                out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [asc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [asc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import asc_pkg::*;
  `include "assert_macros.svh"

  cfg_t      cfg;
  state_t    st;
  state_t    st_next;
  in_item_t  in_q;
  logic      in_q_valid;
  out_item_t result;
  logic      advance;
  logic      cfg_wr;
  logic [TICK_BITS-1:0] new_ticks;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign advance   = in_q_valid && (!out_valid || out_ready);
  assign in_ready  = !in_q_valid || advance;
  assign new_ticks = eff_ticks(cfg_data[TICK_BITS-1:0]);

  asc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  asc_step_logic u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_q),
    .st_next (st_next),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.offset_in_step    <= '0;
      st.substep_size      <= TICKS_RESET;
      st.last_tried_size   <= TICKS_RESET;
      st.steps_completed   <= '0;
      st.steps_in_sample   <= '0;
      st.samples_completed <= '0;
      st.retry_mark        <= 1'b0;
      st.frozen_mark       <= 1'b0;
    end else if (cfg_wr && cfg_index == CFG_TICKS_PER_STEP) begin
      st.offset_in_step  <= '0;
      st.substep_size    <= new_ticks;
      st.last_tried_size <= new_ticks;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  `ASC_ASSERT_NOW(a_size_nonzero, out_valid, out_item.attempt_size != '0 && out_item.next_size != '0, "zero substep size in result")
  `ASC_ASSERT_NOW(a_frozen_no_retry, st.frozen_mark, !st.retry_mark, "retry mark set while frozen")
  `ASC_ASSERT_NEXT(a_frozen_pass, advance && st.frozen_mark, out_item.status == ST_FROZEN, "frozen controller reported non-frozen status")

endmodule

FILE: sv/asc_cfg_regs.sv
// Configuration register file of the adaptive substep controller.
module asc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [asc_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [asc_pkg::CFG_DATA_BITS-1:0] wr_data,
  output asc_pkg::cfg_t                     cfg
);
  import asc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_step   <= TICKS_RESET;
      cfg.steps_per_sample <= SPS_RESET;
      cfg.total_steps      <= TOTAL_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TICKS_PER_STEP:   cfg.ticks_per_step   <= wr_data[TICK_BITS-1:0];
        CFG_STEPS_PER_SAMPLE: cfg.steps_per_sample <= wr_data[TICK_BITS-1:0];
        CFG_TOTAL_STEPS:      cfg.total_steps      <= wr_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/asc_step_logic.sv
// Single-pass next-state and result logic for one attempt report.
module asc_step_logic (
  input  asc_pkg::cfg_t      cfg,
  input  asc_pkg::state_t    st,
  input  asc_pkg::in_item_t  item,
  output asc_pkg::state_t    st_next,
  output asc_pkg::out_item_t result
);
  import asc_pkg::*;

  logic [TICK_BITS-1:0]  ticks;
  logic [TICK_BITS-1:0]  sps;
  logic [TICK_BITS-1:0]  off;
  logic [TICK_BITS-1:0]  left;
  logic [TICK_BITS-1:0]  sz;
  logic                  end_full;
  logic [TICK_BITS:0]    sis_inc;
  logic                  sample_wrap;
  logic                  done_before;
  status_t               status;
  logic [TICK_BITS-1:0]  noff;
  logic [TICK_BITS:0]    ext;
  logic [TICK_BITS-1:0]  rem;

  always_comb begin
    ticks       = eff_ticks(cfg.ticks_per_step);
    sps         = (cfg.steps_per_sample == '0) ? TICK_BITS'(1) : cfg.steps_per_sample;
    off         = (st.offset_in_step >= ticks) ? '0 : st.offset_in_step;
    left        = ticks - off;
    sz          = (st.substep_size == '0 || st.substep_size > left) ? left : st.substep_size;
    end_full    = (sz == left);
    sis_inc     = {1'b0, st.steps_in_sample} + (TICK_BITS+1)'(1);
    sample_wrap = (sis_inc >= {1'b0, sps});
    done_before = (st.steps_completed >= cfg.total_steps);

    if (done_before || st.frozen_mark) begin
      status = ST_FROZEN;
    end else if (item.abort_request) begin
      status = ST_ABORT;
    end else if (item.success) begin
      status = st.retry_mark ? ST_ACCEPT_RETRY : ST_ACCEPT;
    end else if (st.retry_mark) begin
      status = ST_ABORT;
    end else begin
      status = (sz > TICK_BITS'(1)) ? ST_HALVE : ST_MIN_RETRY;
    end

    noff = end_full ? '0 : off + sz;
    ext  = end_full ? {st.last_tried_size, 1'b0} : {sz, 1'b0};
    rem  = ticks - noff;

    st_next                = st;
    st_next.offset_in_step = off;
    st_next.substep_size   = sz;
    if (!done_before) begin
      if (status == ST_ABORT) begin
        st_next.frozen_mark = 1'b1;
      end
      if (status == ST_HALVE || status == ST_MIN_RETRY) begin
        st_next.retry_mark      = (sz == TICK_BITS'(1));
        st_next.last_tried_size = sz;
        if (sz != TICK_BITS'(1)) begin
          st_next.substep_size = sz >> 1;
        end
      end else begin
        st_next.retry_mark = 1'b0;
        if (end_full) begin
          st_next.steps_completed = st.steps_completed + COUNT_BITS'(1);
          if (sample_wrap) begin
            st_next.steps_in_sample   = '0;
            st_next.samples_completed = st.samples_completed + COUNT_BITS'(1);
          end else begin
            st_next.steps_in_sample = sis_inc[TICK_BITS-1:0];
          end
        end
        st_next.offset_in_step  = noff;
        st_next.last_tried_size = sz;
        st_next.substep_size    = (ext < {1'b0, rem}) ? ext[TICK_BITS-1:0] : rem;
      end
    end

    result.status          = status;
    result.attempt_offset  = off;
    result.attempt_size    = sz;
    result.next_offset     = st_next.offset_in_step;
    result.next_size       = st_next.substep_size;
    result.full_steps_done = st_next.steps_completed;
    result.sample_number   = st_next.samples_completed;
    result.at_sample_start = (off == '0) && (st.steps_in_sample == '0);
    result.at_sample_end   = end_full && sample_wrap;
    result.run_done        = (st_next.steps_completed >= cfg.total_steps);
  end

endmodule

FILE: tb/tb.sv
// Testbench of the adaptive substep controller: predicts each outcome and checks it.
`timescale 1ns / 100ps

module tb;
  import asc_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  class substep_scoreboard;
    cfg_t       cfg;
    state_t     st;
    out_item_t  expected_outcomes[$];
    int unsigned mismatches;

    function new();
      cfg.ticks_per_step   = TICKS_RESET;
      cfg.steps_per_sample = SPS_RESET;
      cfg.total_steps      = TOTAL_RESET;
      st = '0;
      st.substep_size    = step_ticks();
      st.last_tried_size = step_ticks();
      mismatches = 0;
    endfunction

    function logic [TICK_BITS-1:0] step_ticks();
      return (cfg.ticks_per_step == '0) ? TICK_BITS'(1) : cfg.ticks_per_step;
    endfunction

    function bit run_over();
      return st.steps_completed >= cfg.total_steps;
    endfunction

    function void write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_TICKS_PER_STEP: begin
          cfg.ticks_per_step = data[TICK_BITS-1:0];
          st.offset_in_step  = '0;
          st.substep_size    = step_ticks();
          st.last_tried_size = step_ticks();
        end
        CFG_STEPS_PER_SAMPLE: cfg.steps_per_sample = data[TICK_BITS-1:0];
        CFG_TOTAL_STEPS: cfg.total_steps = data[COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void advance_substep(in_item_t it);
      out_item_t            r;
      logic [TICK_BITS-1:0] ticks, sps, room;
      logic [TICK_BITS:0]   grow;
      logic                 end_full;
      status_t              code;
      ticks = step_ticks();
      sps = (cfg.steps_per_sample == '0) ? TICK_BITS'(1) : cfg.steps_per_sample;
      if (st.offset_in_step >= ticks) st.offset_in_step = '0;
      room = ticks - st.offset_in_step;
      if (st.substep_size == '0 || st.substep_size > room) st.substep_size = room;
      r.attempt_offset = st.offset_in_step;
      r.attempt_size   = st.substep_size;
      end_full = ((TICK_BITS+1)'(r.attempt_offset) + (TICK_BITS+1)'(r.attempt_size))
                 == (TICK_BITS+1)'(ticks);
      r.at_sample_start = (r.attempt_offset == '0) && (st.steps_in_sample == '0);
      r.at_sample_end = end_full &&
                        ((TICK_BITS+1)'(st.steps_in_sample) + 1 >= (TICK_BITS+1)'(sps));
      if (run_over()) begin
        code = ST_FROZEN;
      end else begin
        if (st.frozen_mark) code = ST_FROZEN;
        else if (it.abort_request) code = ST_ABORT;
        else if (it.success) code = st.retry_mark ? ST_ACCEPT_RETRY : ST_ACCEPT;
        else if (st.retry_mark) code = ST_ABORT;
        else code = (r.attempt_size > 1) ? ST_HALVE : ST_MIN_RETRY;
        if (code == ST_ABORT) st.frozen_mark = 1'b1;
        if (code == ST_HALVE || code == ST_MIN_RETRY) begin
          st.retry_mark      = (r.attempt_size == TICK_BITS'(1));
          st.last_tried_size = r.attempt_size;
          if (!st.retry_mark) st.substep_size = r.attempt_size >> 1;
        end else begin
          st.retry_mark = 1'b0;
          if (end_full) begin
            st.steps_completed = st.steps_completed + 1'b1;
            if ((TICK_BITS+1)'(st.steps_in_sample) + 1 >= (TICK_BITS+1)'(sps)) begin
              st.steps_in_sample   = '0;
              st.samples_completed = st.samples_completed + 1'b1;
            end else begin
              st.steps_in_sample = st.steps_in_sample + 1'b1;
            end
            st.offset_in_step = '0;
            grow = {st.last_tried_size, 1'b0};
          end else begin
            st.offset_in_step = r.attempt_offset + r.attempt_size;
            grow = {r.attempt_size, 1'b0};
          end
          st.last_tried_size = r.attempt_size;
          room = ticks - st.offset_in_step;
          st.substep_size = (grow < (TICK_BITS+1)'(room)) ? grow[TICK_BITS-1:0] : room;
        end
      end
      r.status          = code;
      r.next_offset     = st.offset_in_step;
      r.next_size       = st.substep_size;
      r.full_steps_done = st.steps_completed;
      r.sample_number   = st.samples_completed;
      r.run_done        = run_over();
      expected_outcomes.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_outcome(out_item_t got);
      out_item_t want;
      if (expected_outcomes.size() == 0) begin
        $error("result transaction with none pending, status %0d", got.status);
        mismatches++;
        return;
      end
      want = expected_outcomes.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("attempt_offset", 32'(want.attempt_offset), 32'(got.attempt_offset));
      check_field("attempt_size", 32'(want.attempt_size), 32'(got.attempt_size));
      check_field("next_offset", 32'(want.next_offset), 32'(got.next_offset));
      check_field("next_size", 32'(want.next_size), 32'(got.next_size));
      check_field("full_steps_done", want.full_steps_done, got.full_steps_done);
      check_field("sample_number", want.sample_number, got.sample_number);
      check_field("at_sample_start", 32'(want.at_sample_start), 32'(got.at_sample_start));
      check_field("at_sample_end", 32'(want.at_sample_end), 32'(got.at_sample_end));
      check_field("run_done", 32'(want.run_done), 32'(got.run_done));
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_item_t                 in_item = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_item;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  substep_scoreboard sb;
  bit in_calm, out_calm;

  adaptive_substep_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned pick_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic in_item_t attempt(bit ok, bit quit);
    in_item_t it;
    it.success       = ok;
    it.abort_request = quit;
    return it;
  endfunction

  function automatic in_item_t random_attempt();
    bit done;
    done = sb.run_over();
    return attempt(($urandom_range(0, 3) != 0) || (sb.st.retry_mark && !done),
                   done && ($urandom_range(0, 2) == 0));
  endfunction

  task automatic send_attempt(in_item_t it);
    int unsigned gap;
    gap = pick_wait(in_calm);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.advance_substep(it);
  endtask

  task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned stall;
    forever begin
      stall = pick_wait(out_calm);
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_outcome(out_item);
  end

  initial begin
    logic [TICK_BITS-1:0]  tick_val, sps_val;
    logic [COUNT_BITS-1:0] total_val;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // halve down to one tick, fail there, then recover on the last retry
    repeat (8) send_attempt(attempt(1'b0, 1'b0));
    repeat (5) send_attempt(attempt(1'b1, 1'b0));

    drain();
    write_cfg(CFG_TICKS_PER_STEP, {16'hA5C3, 16'd0});
    write_cfg(CFG_STEPS_PER_SAMPLE, {16'h5A3C, 16'd0});
    write_cfg(CFG_TOTAL_STEPS, sb.st.steps_completed + 2);
    write_cfg(CFG_SPARE, $urandom);
    repeat (3) send_attempt(attempt(1'b1, 1'b0));
    send_attempt(attempt(1'b0, 1'b1));
    send_attempt(attempt(1'b1, 1'b1));

    drain();
    write_cfg(CFG_TICKS_PER_STEP, 32'hFFFF_FFFF);
    write_cfg(CFG_STEPS_PER_SAMPLE, 32'h0000_FFFF);
    write_cfg(CFG_TOTAL_STEPS, 32'd0);
    send_attempt(attempt(1'b0, 1'b0));
    send_attempt(attempt(1'b1, 1'b0));

    drain();
    write_cfg(CFG_TOTAL_STEPS, 32'hFFFF_FFFF);
    write_cfg(CFG_STEPS_PER_SAMPLE, 32'd3);
    repeat (2) send_attempt(attempt(1'b1, 1'b0));
    send_attempt(attempt(1'b0, 1'b0));

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0: tick_val = 16'd0;
          1: tick_val = 16'd1;
          2: tick_val = 16'hFFFF;
          3: tick_val = 16'($urandom_range(2, 16));
          4: tick_val = 16'($urandom_range(17, 300));
          default: tick_val = 16'($urandom_range(301, 65534));
        endcase
        write_cfg(CFG_TICKS_PER_STEP, {16'($urandom), tick_val});
      end
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 4))
          0: sps_val = 16'd0;
          1: sps_val = 16'd1;
          2: sps_val = 16'hFFFF;
          default: sps_val = 16'($urandom_range(2, 6));
        endcase
        write_cfg(CFG_STEPS_PER_SAMPLE, {16'($urandom), sps_val});
      end
      case ($urandom_range(0, 7))
        0: total_val = '0;
        1, 2: total_val = '1;
        3: total_val = $urandom;
        default: total_val = sb.st.steps_completed + $urandom_range(1, 150);
      endcase
      write_cfg(CFG_TOTAL_STEPS, total_val);
      repeat (170) send_attempt(random_attempt());
    end

    // drive into a last retry, then abort and stay frozen
    drain();
    write_cfg(CFG_TOTAL_STEPS, 32'hFFFF_FFFF);
    write_cfg(CFG_TICKS_PER_STEP, 32'($urandom_range(4, 64)));
    while (!sb.st.retry_mark) send_attempt(attempt(1'b0, 1'b0));
    case ($urandom_range(0, 2))
      0: send_attempt(attempt(1'b0, 1'b0));
      1: send_attempt(attempt(1'b0, 1'b1));
      default: send_attempt(attempt(1'b1, 1'b1));
    endcase
    repeat (20) send_attempt(attempt($urandom_range(0, 1), $urandom_range(0, 1)));

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_outcomes.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+sv
sv/asc_pkg.sv
sv/asc_cfg_regs.sv
sv/asc_step_logic.sv
sv/adaptive_substep_controller.sv
tb/tb.sv
